/* design/pss_pkg.sv */
package pss_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W  = 16;
    localparam int PRI_W = 8;
    localparam int OCC_W = 5;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_port;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] tag;
    } t_scan_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOCATE,
        S_SHIFT
    } t_state;

endpackage

/* design/priority_select_scheduler.sv */
// Channel   | Handshake        | Ports
// ----------+------------------+-----------------------------------------------
// request   | start & !busy    | i_req_type, i_proc_id, i_prio
// result    | o_done (1 cycle) | o_out_id, o_out_valid, o_empty_err,
//           |                  | o_full_err, o_occupancy
//
// For an enqueue, a dequeue on an empty store, or an enqueue on a full store,
// the result strobes in the cycle after acceptance and busy never rises.
// A dequeue on a non-empty store keeps busy high while the single read port
// of the entry store is swept once for the priority compare and again, from
// the slot after the winner, to close the gap, one entry per cycle; when the
// winner is the newest entry nothing has to move. The result strobes in the
// same cycle that busy falls. Reset is synchronous and empties the store
// at once. The receiver cannot stall the result.
module priority_select_scheduler
    import pss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_req_type,
    input  logic [ID_W-1:0]  i_proc_id,
    input  logic [PRI_W-1:0] i_prio,
    output logic             o_done,
    output logic [ID_W-1:0]  o_out_id,
    output logic             o_out_valid,
    output logic             o_empty_err,
    output logic             o_full_err,
    output logic [OCC_W-1:0] o_occupancy
);

    t_wr_port         wr;
    logic [IDX_W-1:0] ra;
    t_entry           rd;
    t_scan_req        scan;
    logic [IDX_W-1:0] best_idx;
    logic [ID_W-1:0]  best_id;

    pss_store u_store (
        .i_clk (i_clk),
        .i_wr  (wr),
        .i_ra  (ra),
        .o_rd  (rd)
    );

    pss_scan u_scan (
        .i_clk      (i_clk),
        .i_req      (scan),
        .i_entry    (rd),
        .o_best_idx (best_idx),
        .o_best_id  (best_id)
    );

    pss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_proc_id   (i_proc_id),
        .i_prio      (i_prio),
        .o_done      (o_done),
        .o_out_id    (o_out_id),
        .o_out_valid (o_out_valid),
        .o_empty_err (o_empty_err),
        .o_full_err  (o_full_err),
        .o_occupancy (o_occupancy),
        .o_wr        (wr),
        .o_ra        (ra),
        .i_rd        (rd),
        .o_scan      (scan),
        .i_best_idx  (best_idx),
        .i_best_id   (best_id)
    );

endmodule

/* design/pss_store.sv */
module pss_store
    import pss_pkg::*;
(
    input  logic             i_clk,
    input  t_wr_port         i_wr,
    input  logic [IDX_W-1:0] i_ra,
    output t_entry           o_rd
);

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

/* design/pss_scan.sv */
module pss_scan
    import pss_pkg::*;
(
    input  logic             i_clk,
    input  t_scan_req        i_req,
    input  t_entry           i_entry,
    output logic [IDX_W-1:0] o_best_idx,
    output logic [ID_W-1:0]  o_best_id
);

    logic [IDX_W-1:0] r_best_idx;
    logic [PRI_W-1:0] r_best_prio;
    logic [ID_W-1:0]  r_best_id;
    logic             better;

    // Strictly greater keeps the earliest arrival on a tie.
    assign better = (i_req.tag == '0) || (i_entry.prio > r_best_prio);

    always_ff @(posedge i_clk) begin
        if (i_req.load && better) begin
            r_best_idx  <= i_req.tag;
            r_best_prio <= i_entry.prio;
            r_best_id   <= i_entry.id;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_id  = r_best_id;

endmodule

/* design/pss_ctrl.sv */
module pss_ctrl
    import pss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_req_type,
    input  logic [ID_W-1:0]  i_proc_id,
    input  logic [PRI_W-1:0] i_prio,
    output logic             o_done,
    output logic [ID_W-1:0]  o_out_id,
    output logic             o_out_valid,
    output logic             o_empty_err,
    output logic             o_full_err,
    output logic [OCC_W-1:0] o_occupancy,
    output t_wr_port         o_wr,
    output logic [IDX_W-1:0] o_ra,
    input  t_entry           i_rd,
    output t_scan_req        o_scan,
    input  logic [IDX_W-1:0] i_best_idx,
    input  logic [ID_W-1:0]  i_best_id
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_ptr;
    logic             r_pend;
    logic [IDX_W-1:0] r_tag;
    logic             r_done;
    logic [ID_W-1:0]  r_out_id;
    logic             r_out_valid;
    logic             r_empty;
    logic             r_full;
    logic [CNT_W-1:0] r_occ;

    logic accept;
    logic is_full;
    logic is_empty;
    logic issue;
    logic phase_done;

    assign accept     = start && (r_state == S_IDLE);
    assign is_full    = (r_cnt == CNT_W'(DEPTH));
    assign is_empty   = (r_cnt == '0);
    assign issue      = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_ptr < r_cnt);
    assign phase_done = (r_ptr >= r_cnt) && !r_pend;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == REQ_DEQ) && !is_empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (phase_done) begin
                    n_state = S_LOCATE;
                end
            end
            S_LOCATE: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (phase_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Store write port and scan unit control.
    always_comb begin
        o_wr       = '0;
        o_scan     = '0;
        o_scan.tag = r_tag;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == REQ_ENQ) && !is_full) begin
                    o_wr.we        = 1'b1;
                    o_wr.addr      = r_cnt[IDX_W-1:0];
                    o_wr.data.id   = i_proc_id;
                    o_wr.data.prio = i_prio;
                end
            end
            S_SCAN: begin
                o_scan.load = r_pend;
            end
            S_LOCATE: begin
                o_wr.we = 1'b0;
            end
            S_SHIFT: begin
                // Each entry after the removed one moves down by one slot.
                if (r_pend) begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = r_tag - IDX_W'(1);
                    o_wr.data = i_rd;
                end
            end
            default: begin
                o_wr.we = 1'b0;
            end
        endcase
    end

    assign o_ra = r_ptr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            r_done  <= (accept && ((i_req_type == REQ_ENQ) || is_empty)) ||
                       ((r_state == S_SHIFT) && phase_done);
            if (accept) begin
                r_ptr <= '0;
                if ((i_req_type == REQ_ENQ) && !is_full) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (r_state == S_LOCATE) begin
                r_ptr <= CNT_W'(i_best_idx) + CNT_W'(1);
            end else if (issue) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if ((r_state == S_SHIFT) && phase_done) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= r_ptr[IDX_W-1:0];
        if (accept) begin
            r_out_id    <= '0;
            r_out_valid <= 1'b0;
            r_empty     <= (i_req_type == REQ_DEQ) && is_empty;
            r_full      <= (i_req_type == REQ_ENQ) && is_full;
            r_occ       <= ((i_req_type == REQ_ENQ) && !is_full) ? r_cnt + CNT_W'(1) : r_cnt;
        end else if ((r_state == S_SHIFT) && phase_done) begin
            r_out_id    <= i_best_id;
            r_out_valid <= 1'b1;
            r_empty     <= 1'b0;
            r_full      <= 1'b0;
            r_occ       <= r_cnt - CNT_W'(1);
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_out_id    = r_out_id;
    assign o_out_valid = r_out_valid;
    assign o_empty_err = r_empty;
    assign o_full_err  = r_full;
    assign o_occupancy = OCC_W'(r_occ);

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import pss_pkg::*;

    localparam int DIRECTED_COUNT = 16;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 4 * DEPTH + 8;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             valid;
        logic             empty_err;
        logic             full_err;
        logic [OCC_W-1:0] occ;
    } t_sched_result;

    // Tracks the entries held by the scheduler in arrival order and the
    // results still owed for transactions that have been accepted.
    class sched_scoreboard;
        logic [ID_W-1:0]  held_ids[$];
        logic [PRI_W-1:0] held_prios[$];
        t_sched_result    owed[$];
        int               mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void flag(string what, t_sched_result want, t_sched_result got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: %s: expected id=%h valid=%b empty=%b full=%b occ=%0d,",
                          " got id=%h valid=%b empty=%b full=%b occ=%0d"},
                         $time, what, want.id, want.valid, want.empty_err, want.full_err,
                         want.occ, got.id, got.valid, got.empty_err, got.full_err, got.occ);
        endfunction

        function void note_request(logic req, logic [ID_W-1:0] id, logic [PRI_W-1:0] pr);
            t_sched_result r;
            int            best;
            int            k;
            r = '0;
            if (req == REQ_ENQ) begin
                if (held_ids.size() >= DEPTH) begin
                    r.full_err = 1'b1;
                end else begin
                    held_ids.push_back(id);
                    held_prios.push_back(pr);
                end
            end else if (held_ids.size() == 0) begin
                r.empty_err = 1'b1;
            end else begin
                // Strictly greater wins, so the oldest entry keeps a tie.
                best = 0;
                for (k = 1; k < held_prios.size(); k++) begin
                    if (held_prios[k] > held_prios[best])
                        best = k;
                end
                r.id    = held_ids[best];
                r.valid = 1'b1;
                held_ids.delete(best);
                held_prios.delete(best);
            end
            r.occ = OCC_W'(held_ids.size());
            owed.push_back(r);
        endfunction

        function void check_result(t_sched_result got);
            t_sched_result want;
            if (owed.size() == 0) begin
                flag("result with no transaction pending", '0, got);
                return;
            end
            want = owed.pop_front();
            if (got.id !== want.id || got.valid !== want.valid ||
                got.empty_err !== want.empty_err || got.full_err !== want.full_err ||
                got.occ !== want.occ)
                flag("result mismatch", want, got);
        endfunction

        function void drain_check();
            if (owed.size() > 0) begin
                flag("transaction without a result", owed[0], '0);
                mismatches += owed.size() - 1;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    logic             i_req_type  = REQ_ENQ;
    logic [ID_W-1:0]  i_proc_id   = '0;
    logic [PRI_W-1:0] i_prio      = '0;
    logic             o_done;
    logic [ID_W-1:0]  o_out_id;
    logic             o_out_valid;
    logic             o_empty_err;
    logic             o_full_err;
    logic [OCC_W-1:0] o_occupancy;

    sched_scoreboard sb = new();
    t_sched_result   seen_result;
    int              stall_cycles = 0;

    priority_select_scheduler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_proc_id   (i_proc_id),
        .i_prio      (i_prio),
        .o_done      (o_done),
        .o_out_id    (o_out_id),
        .o_out_valid (o_out_valid),
        .o_empty_err (o_empty_err),
        .o_full_err  (o_full_err),
        .o_occupancy (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                seen_result.id        = o_out_id;
                seen_result.valid     = o_out_valid;
                seen_result.empty_err = o_empty_err;
                seen_result.full_err  = o_full_err;
                seen_result.occ       = o_occupancy;
                sb.check_result(seen_result);
            end
            if (start && !busy)
                sb.note_request(i_req_type, i_proc_id, i_prio);
            if (o_done || (start && !busy)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Presents one transaction, holds it until accepted, then optionally idles.
    task automatic issue_request(input logic req, input logic [ID_W-1:0] id,
                                 input logic [PRI_W-1:0] pr, input int gap);
        start      <= 1'b1;
        i_req_type <= req;
        i_proc_id  <= id;
        i_prio     <= pr;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [PRI_W-1:0] pick_prio(int mode);
        case (mode)
            0: pick_prio = PRI_W'($urandom);
            1: pick_prio = PRI_W'($urandom_range(40, 42));
            default: pick_prio = $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0: pick_id = '0;
            1: pick_id = '1;
            default: pick_id = ID_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [PRI_W-1:0] fill_prios[DIRECTED_COUNT];
        logic             req;
        int               sent;
        int               seg_len;
        int               enq_pct;
        int               prio_mode;
        int               gap;
        bit               quiet;
        int               i;
        int               j;

        fill_prios = '{8'd0, 8'd255, 8'd255, 8'd7, 8'd128, 8'd1, 8'd254, 8'd7,
                       8'd0, 8'd255, 8'd64, 8'd64, 8'd200, 8'd3, 8'd128, 8'd255};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store, a full fill with ties and extreme values, an overflow,
        // then dequeues that walk down through the tied priorities.
        issue_request(REQ_DEQ, '1, '1, 0);
        for (i = 0; i < DIRECTED_COUNT; i++) begin
            if (i == 0)
                issue_request(REQ_ENQ, '0, fill_prios[i], 0);
            else if (i == 1)
                issue_request(REQ_ENQ, '1, fill_prios[i], 0);
            else
                issue_request(REQ_ENQ, ID_W'(16'h5A00 + i), fill_prios[i], 0);
        end
        issue_request(REQ_ENQ, 16'hBEEF, '1, 0);
        for (i = 0; i < 7; i++)
            issue_request(REQ_DEQ, '0, '0, (i == 3) ? 5 : 0);

        // Random segments with a varying enqueue bias so the store keeps
        // swinging between empty and full.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len   = $urandom_range(8, 60);
            prio_mode = $urandom_range(0, 2);
            case ($urandom_range(0, 4))
                0: enq_pct = 10;
                1: enq_pct = 35;
                2: enq_pct = 50;
                3: enq_pct = 65;
                default: enq_pct = 90;
            endcase
            quiet = ($urandom_range(0, 3) == 0) || (sent > RANDOM_ITEMS * 85 / 100);
            for (j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
                req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
                issue_request(req, pick_id(), pick_prio(prio_mode), gap);
                sent++;
            end
        end
        start <= 1'b0;

        while (sb.owed.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.drain_check();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/pss_pkg.sv
design/pss_store.sv
design/pss_scan.sv
design/pss_ctrl.sv
design/priority_select_scheduler.sv
test/tb.sv
